FILE: rtl/core/scae_pkg.sv
package scae_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam int unsigned CELL_ROWS       = 8;

  localparam logic [1:0] KIND_BITMAP = 2'd0;
  localparam logic [1:0] KIND_ATTR   = 2'd1;
  localparam logic [1:0] KIND_BAD    = 2'd2;
  localparam logic [1:0] KIND_THIRD  = 2'd3;

  localparam logic [7:0] CHAN_HALF = 8'd192;
  localparam logic [7:0] CHAN_FULL = 8'd255;
  localparam logic [5:0] PIX_LAST  = 6'd63;
  localparam logic [7:0] ATTR_BLACK = 8'd7;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [9:0] cell_index;
    logic [5:0] pixel_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [12:0] address;
    logic [7:0]  data;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic        last;
  } out_item_t;

  // one finished cell or one error, front to back
  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] bitmap;
    logic [7:0]  attr;
    logic [9:0]  cell_idx;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
  } job_t;

endpackage

FILE: rtl/core/scae_front.sv
module scae_front
  import scae_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t in_item,
  output logic     job_valid,
  output job_t     job
);

  logic [3:0]  paper_r, paper_nxt;
  logic [3:0]  ink_r, ink_nxt;
  logic [63:0] bm_r, bm_nxt;
  logic        halted_r, halted_nxt;

  logic        r_ok, g_ok, b_ok, any_half, any_full, bad;
  logic [3:0]  c, p_e, i_e;
  logic [63:0] bm_e, bm_out;
  logic [7:0]  attr;
  logic        third_err;
  logic [1:0]  third;
  logic [7:0]  j;

  always_comb begin
    r_ok = (in_item.red == '0) || (in_item.red == CHAN_HALF) || (in_item.red == CHAN_FULL);
    g_ok = (in_item.green == '0) || (in_item.green == CHAN_HALF) ||
           (in_item.green == CHAN_FULL);
    b_ok = (in_item.blue == '0) || (in_item.blue == CHAN_HALF) ||
           (in_item.blue == CHAN_FULL);
    any_half = (in_item.red == CHAN_HALF) || (in_item.green == CHAN_HALF) ||
               (in_item.blue == CHAN_HALF);
    any_full = (in_item.red == CHAN_FULL) || (in_item.green == CHAN_FULL) ||
               (in_item.blue == CHAN_FULL);
    bad = !(r_ok && g_ok && b_ok) || (any_half && any_full);

    c = {any_full, in_item.green[7], in_item.red[7], in_item.blue[7]};

    third = in_item.cell_index[9:8];
    j     = in_item.cell_index[7:0];

    if (in_item.pixel_index == '0) begin
      p_e  = c;
      i_e  = c;
      bm_e = '0;
    end else begin
      p_e  = paper_r;
      i_e  = ink_r;
      bm_e = bm_r;
    end

    third_err = (c != i_e) && (c != p_e) && (i_e != p_e);
    if ((c != i_e) && (c != p_e)) begin
      i_e = c;
    end
    bm_e = {bm_e[62:0], c != p_e};

    if (p_e == i_e) begin
      if (i_e != '0) begin
        bm_out = '1;
        attr   = {1'b0, i_e[3], 3'b000, i_e[2:0]};
      end else begin
        bm_out = '0;
        attr   = ATTR_BLACK;
      end
    end else if (p_e < i_e) begin
      bm_out = bm_e;
      attr   = {1'b0, p_e[3] | i_e[3], p_e[2:0], i_e[2:0]};
    end else begin
      bm_out = ~bm_e;
      attr   = {1'b0, p_e[3] | i_e[3], i_e[2:0], p_e[2:0]};
    end

    job.kind     = bad ? KIND_BAD : (third_err ? KIND_THIRD : KIND_BITMAP);
    job.bitmap   = bm_out;
    job.attr     = attr;
    job.cell_idx = in_item.cell_index;
    job.pixel_x  = {j[4:0], in_item.pixel_index[2:0]};
    job.pixel_y  = {third, j[7:5], in_item.pixel_index[5:3]};

    job_valid  = 1'b0;
    paper_nxt  = paper_r;
    ink_nxt    = ink_r;
    bm_nxt     = bm_r;
    halted_nxt = halted_r;
    if (accept && !halted_r) begin
      if (bad || third_err) begin
        job_valid  = 1'b1;
        halted_nxt = 1'b1;
      end else begin
        paper_nxt = p_e;
        ink_nxt   = i_e;
        bm_nxt    = bm_e;
        job_valid = (in_item.pixel_index == PIX_LAST);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      paper_r  <= '0;
      ink_r    <= '0;
      bm_r     <= '0;
      halted_r <= 1'b0;
    end else begin
      paper_r  <= paper_nxt;
      ink_r    <= ink_nxt;
      bm_r     <= bm_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

FILE: rtl/core/scae_queue.sv
module scae_queue
  import scae_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t            mem [DEPTH];
  logic [PW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    full  = (cnt_r == CW'(DEPTH));
    valid = (cnt_r != '0);
    head  = mem[rd_r];
    wr_nxt = wr_r;
    rd_nxt = rd_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    cnt_nxt = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop)) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !valid)) else $error("pop from empty queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("queue count out of range");
`endif

endmodule

FILE: rtl/core/scae_back.sv
module scae_back
  import scae_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic [1:0] cfg_wdata,
  input  logic      q_valid,
  input  job_t      q_head,
  output logic      q_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  logic [1:0] thirds_r, thirds_nxt;
  logic [3:0] k_r, k_nxt;
  logic       ov_r, ov_nxt;
  out_item_t  out_r, out_nxt;
  logic       adv;
  logic [7:0] j;
  logic [1:0] third;

  always_comb begin
    out_empty = !ov_r;
    out_item  = out_r;
    thirds_nxt = cfg_we ? cfg_wdata : thirds_r;

    j     = q_head.cell_idx[7:0];
    third = q_head.cell_idx[9:8];
    adv   = q_valid && (!ov_r || out_pop);

    k_nxt   = k_r;
    q_pop   = 1'b0;
    out_nxt = out_r;
    ov_nxt  = ov_r && !out_pop;

    if (adv) begin
      ov_nxt = 1'b1;
      if (q_head.kind != KIND_BITMAP) begin
        out_nxt.kind    = q_head.kind;
        out_nxt.address = '0;
        out_nxt.data    = '0;
        out_nxt.pixel_x = q_head.pixel_x;
        out_nxt.pixel_y = q_head.pixel_y;
        out_nxt.last    = 1'b1;
        q_pop           = 1'b1;
      end else if (k_r < 4'(CELL_ROWS)) begin
        out_nxt.kind    = KIND_BITMAP;
        out_nxt.address = {third, k_r[2:0], j};
        out_nxt.data    = q_head.bitmap[(3'(CELL_ROWS - 1) - k_r[2:0]) * 8 +: 8];
        out_nxt.pixel_x = '0;
        out_nxt.pixel_y = '0;
        out_nxt.last    = 1'b0;
        k_nxt           = k_r + 1'b1;
      end else begin
        out_nxt.kind    = KIND_ATTR;
        out_nxt.address = {thirds_r, 11'b0} + {3'b000, third, j};
        out_nxt.data    = q_head.attr;
        out_nxt.pixel_x = '0;
        out_nxt.pixel_y = '0;
        out_nxt.last    = 1'b1;
        k_nxt           = '0;
        q_pop           = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thirds_r <= 2'd3;
      k_r      <= '0;
      ov_r     <= 1'b0;
    end else begin
      thirds_r <= thirds_nxt;
      k_r      <= k_nxt;
      ov_r     <= ov_nxt;
    end
  end

`ifndef SYNTH
  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= 4'(CELL_ROWS)) else $error("row counter out of range");
  a_mid_cell_job: assert property (@(posedge clk) disable iff (!rst_n)
    (k_r != '0) |-> (q_valid && q_head.kind == KIND_BITMAP))
    else $error("cell job lost mid-sequence");
  a_pop_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (k_r == '0 && out_r.last)) else $error("job popped before last item");
`endif

endmodule

FILE: rtl/core/spectrum_cell_attribute_encoder_top.sv
// Throughput: one pixel item per cycle while in_full is low; a cell end yields nine items,
// one per cycle while out_pop takes them. A cell or error result passes through the job
// queue and then the output register before it shows on the out_ ports.
// in_full rises only while all queue entries hold jobs; a cell job is popped with its last item.
// Reset: synchronous active-low rst_n clears colours, bitmap, halt flag and row counter,
// empties queue and output; thirds returns to 3. An error halts the block until reset.
module spectrum_cell_attribute_encoder_top
  import scae_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  in_item_t   in_item,
  output logic       out_empty,
  input  logic       out_pop,
  output out_item_t  out_item,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata
);

  logic accept;
  logic job_valid;
  job_t job;
  logic q_valid, q_pop;
  job_t q_head;

  assign accept = in_push && !in_full;

  scae_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_item   (in_item),
    .job_valid (job_valid),
    .job       (job)
  );

  scae_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_valid),
    .push_job (job),
    .full     (in_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  scae_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

FILE: tb/sv/spectrum_cell_attribute_encoder_top_test.sv
module spectrum_cell_attribute_encoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import scae_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_PIXELS = 60;

  typedef struct {
    in_item_t    pixel;
    bit          known;
    logic [1:0]  kind;
    logic [12:0] addr;
    logic [7:0]  data;
    logic [12:0] attr_addr;
    logic [7:0]  attr_data;
    logic [7:0]  x;
    logic [7:0]  y;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  in_item_t  in_item;
  logic      out_empty;
  logic      out_pop;
  out_item_t out_item;
  logic      cfg_we;
  logic [1:0] cfg_wdata;

  logic [3:0]  cur_paper   = '0;
  logic [3:0]  cur_ink     = '0;
  logic [63:0] cur_rows    = '0;
  bit          stopped     = 1'b0;
  logic [1:0]  attr_thirds = 2'd3;

  out_item_t cell_bytes_new[$];
  out_item_t screen_bytes_due[$];
  out_item_t oldest;
  stim_row_t plan[$];

  int in_gap_pct    = 6;
  int out_stall_pct = 6;
  int pixels_sent   = 0;
  int error_count   = 0;
  int cycle_count   = 0;
  int fault_pick;

  spectrum_cell_attribute_encoder_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic out_item_t screen_byte(logic [1:0] kind, logic [12:0] addr,
                                            logic [7:0] data, logic [7:0] x,
                                            logic [7:0] y, logic last);
    out_item_t b;
    b.kind    = kind;
    b.address = addr;
    b.data    = data;
    b.pixel_x = x;
    b.pixel_y = y;
    b.last    = last;
    return b;
  endfunction

  function automatic bit chan_valid(logic [7:0] v);
    return v == 8'd0 || v == CHAN_HALF || v == CHAN_FULL;
  endfunction

  function automatic void encode_pixel(in_item_t it);
    logic [1:0]  third;
    logic [7:0]  j;
    logic [7:0]  px;
    logic [7:0]  py;
    logic [7:0]  attr;
    logic [3:0]  c;
    logic [3:0]  p;
    logic [3:0]  i;
    logic [63:0] bm;
    bit          has_half;
    bit          has_full;
    third = it.cell_index[9:8];
    j     = it.cell_index[7:0];
    px    = {j[4:0], it.pixel_index[2:0]};
    py    = {third, j[7:5], it.pixel_index[5:3]};
    cell_bytes_new.delete();
    if (stopped) return;
    has_half = it.red == CHAN_HALF || it.green == CHAN_HALF || it.blue == CHAN_HALF;
    has_full = it.red == CHAN_FULL || it.green == CHAN_FULL || it.blue == CHAN_FULL;
    if (!(chan_valid(it.red) && chan_valid(it.green) && chan_valid(it.blue)) ||
        (has_half && has_full)) begin
      stopped = 1'b1;
      cell_bytes_new.push_back(screen_byte(KIND_BAD, '0, '0, px, py, 1'b1));
      return;
    end
    c = {(it.red | it.green | it.blue) == CHAN_FULL, it.green[7], it.red[7], it.blue[7]};
    if (it.pixel_index == 6'd0) begin
      cur_paper = c;
      cur_ink   = c;
      cur_rows  = '0;
    end
    if (c != cur_ink && c != cur_paper) begin
      if (cur_ink != cur_paper) begin
        stopped = 1'b1;
        cell_bytes_new.push_back(screen_byte(KIND_THIRD, '0, '0, px, py, 1'b1));
        return;
      end
      cur_ink = c;
    end
    cur_rows = {cur_rows[62:0], c != cur_paper};
    if (it.pixel_index != PIX_LAST) return;
    p  = cur_paper;
    i  = cur_ink;
    bm = cur_rows;
    if (p == i) begin
      if (i != 4'd0) begin
        bm   = '1;
        attr = {1'b0, i[3], 3'b000, i[2:0]};
      end else begin
        bm   = '0;
        attr = ATTR_BLACK;
      end
    end else if (p < i) begin
      attr = {1'b0, p, 3'b000} | {1'b0, i[3], 3'b000, i[2:0]};
    end else begin
      // paper brighter than ink: swap roles and invert the bitmap
      bm   = ~bm;
      attr = {1'b0, i, 3'b000} | {1'b0, p[3], 3'b000, p[2:0]};
    end
    for (int k = 0; k < CELL_ROWS; k++) begin
      cell_bytes_new.push_back(screen_byte(KIND_BITMAP, {third, k[2:0], j},
                                           bm[63 - 8 * k -: 8], '0, '0, 1'b0));
    end
    cell_bytes_new.push_back(screen_byte(KIND_ATTR, {attr_thirds, 11'd0} + {3'd0, third, j},
                                         attr, '0, '0, 1'b1));
  endfunction

  function automatic in_item_t paint(logic [3:0] c, logic [9:0] cell_no, logic [5:0] pix);
    in_item_t   it;
    logic [7:0] level;
    level          = c[3] ? CHAN_FULL : CHAN_HALF;
    it.red         = c[1] ? level : 8'd0;
    it.green       = c[2] ? level : 8'd0;
    it.blue        = c[0] ? level : 8'd0;
    it.cell_index  = cell_no;
    it.pixel_index = pix;
    return it;
  endfunction

  function automatic stim_row_t pixel_row(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                          logic [9:0] cell_no, logic [5:0] pix);
    stim_row_t s;
    s.pixel.red         = r;
    s.pixel.green       = g;
    s.pixel.blue        = b;
    s.pixel.cell_index  = cell_no;
    s.pixel.pixel_index = pix;
    s.known             = 1'b0;
    s.kind              = KIND_BITMAP;
    s.addr              = '0;
    s.data              = '0;
    s.attr_addr         = '0;
    s.attr_data         = '0;
    s.x                 = '0;
    s.y                 = '0;
    return s;
  endfunction

  task automatic add_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                           logic [9:0] cell_no, logic [5:0] pix);
    plan.push_back(pixel_row(r, g, b, cell_no, pix));
  endtask

  task automatic add_known(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                           logic [9:0] cell_no, logic [5:0] pix, logic [1:0] kind,
                           logic [12:0] addr, logic [7:0] data, logic [12:0] attr_addr,
                           logic [7:0] attr_data, logic [7:0] x, logic [7:0] y);
    stim_row_t s;
    s           = pixel_row(r, g, b, cell_no, pix);
    s.known     = 1'b1;
    s.kind      = kind;
    s.addr      = addr;
    s.data      = data;
    s.attr_addr = attr_addr;
    s.attr_data = attr_data;
    s.x         = x;
    s.y         = y;
    plan.push_back(s);
  endtask

  task automatic push_pixel(in_item_t it, bit known);
    @(negedge clk);
    while ($urandom_range(99) < in_gap_pct) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_item = it;
    in_push = 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    pixels_sent++;
    encode_pixel(it);
    if (!known) begin
      foreach (cell_bytes_new[q]) screen_bytes_due.push_back(cell_bytes_new[q]);
    end
  endtask

  task automatic play_plan();
    stim_row_t s;
    for (int r = 0; r < plan.size(); r++) begin
      s = plan[r];
      push_pixel(s.pixel, s.known);
      if (s.known) begin
        if (s.kind == KIND_BAD || s.kind == KIND_THIRD) begin
          screen_bytes_due.push_back(screen_byte(s.kind, '0, '0, s.x, s.y, 1'b1));
        end else begin
          for (int k = 0; k < CELL_ROWS; k++) begin
            screen_bytes_due.push_back(screen_byte(KIND_BITMAP,
                                                   s.addr | {2'b00, k[2:0], 8'h00},
                                                   s.data, '0, '0, 1'b0));
          end
          screen_bytes_due.push_back(screen_byte(KIND_ATTR, s.attr_addr, s.attr_data,
                                                 '0, '0, 1'b1));
        end
      end
    end
    plan.delete();
  endtask

  task automatic set_thirds(logic [1:0] v);
    @(negedge clk);
    in_push = 1'b0;
    while (screen_bytes_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we      = 1'b0;
    attr_thirds = v;
  endtask

  // whole cell in order, two colours at most, sometimes cut short
  task automatic send_cell();
    logic [9:0] cell_no;
    logic [3:0] c0;
    logic [3:0] c1;
    int         upto;
    cell_no = 10'($urandom_range(1023));
    c0      = 4'($urandom_range(15));
    c1      = 4'($urandom_range(15));
    if ($urandom_range(4) == 0) c1 = c0;
    if ($urandom_range(9) == 0) begin
      c0 = 4'd0;
      c1 = 4'd0;
    end
    upto = 63;
    if ($urandom_range(4) == 0) upto = $urandom_range(1, 62);
    for (int p = 0; p <= upto; p++) begin
      push_pixel(paint((p == 0 || $urandom_range(1) == 0) ? c0 : c1, cell_no, p[5:0]),
                 1'b0);
    end
  endtask

  // pixels out of order; colours kept legal against the held pair
  task automatic send_scatter();
    logic [9:0] cell_no;
    logic [5:0] pix;
    logic [3:0] c;
    int         n;
    n       = $urandom_range(3, 12);
    cell_no = 10'($urandom_range(1023));
    for (int q = 0; q < n; q++) begin
      pix = 6'($urandom_range(63));
      if (q == n - 1 && $urandom_range(1) == 1) pix = PIX_LAST;
      if (pix == 6'd0 || cur_paper == cur_ink) c = 4'($urandom_range(15));
      else if ($urandom_range(1) == 1) c = cur_paper;
      else c = cur_ink;
      push_pixel(paint(c, cell_no, pix), 1'b0);
    end
  endtask

  task automatic random_pixels(int goal);
    while (pixels_sent < goal) begin
      if ($urandom_range(3) != 0) send_cell();
      else send_scatter();
    end
  endtask

  task automatic check_field(string name, logic [12:0] want, logic [12:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      out_pop = $urandom_range(99) >= out_stall_pct;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("spectrum_cell_attribute_encoder_top regression: fail");
      $finish;
    end else if (rst_n && out_pop && !out_empty) begin
      if (screen_bytes_due.size() == 0) begin
        $error("result with none due: kind %0d address %0d", out_item.kind, out_item.address);
        error_count++;
      end else begin
        oldest = screen_bytes_due.pop_front();
        check_field("kind", oldest.kind, out_item.kind);
        check_field("address", oldest.address, out_item.address);
        check_field("data", oldest.data, out_item.data);
        check_field("pixel_x", oldest.pixel_x, out_item.pixel_x);
        check_field("pixel_y", oldest.pixel_y, out_item.pixel_y);
        check_field("last", oldest.last, out_item.last);
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_push   = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    add_known(0, 0, 0, 0, 63, KIND_BITMAP, 13'd0, 8'h00, 13'd6144, 8'h07, 0, 0);
    add_pixel(255, 255, 255, 1023, 0);
    add_known(255, 255, 255, 1023, 63, KIND_BITMAP, 13'd6399, 8'hff, 13'd7167, 8'h47, 0, 0);
    add_pixel(0, 0, 192, 5, 0);
    add_pixel(192, 0, 0, 5, 1);
    add_pixel(0, 0, 192, 5, 63);
    add_pixel(255, 255, 255, 300, 0);
    add_pixel(0, 192, 0, 300, 9);
    add_pixel(0, 192, 0, 300, 63);
    add_pixel(0, 192, 0, 767, 17);
    add_pixel(255, 255, 255, 767, 5);
    add_pixel(0, 192, 0, 767, 63);
    add_pixel(0, 192, 0, 768, 40);
    add_pixel(192, 192, 192, 768, 0);
    add_pixel(255, 0, 255, 768, 63);
    add_pixel(192, 0, 0, 512, 0);
    add_known(192, 0, 0, 512, 63, KIND_BITMAP, 13'd4096, 8'hff, 13'd6656, 8'h02, 0, 0);
    add_pixel(0, 0, 0, 64, 0);
    add_known(0, 0, 0, 64, 63, KIND_BITMAP, 13'd64, 8'h00, 13'd6208, 8'h07, 0, 0);
    add_pixel(255, 255, 0, 0, 0);
    add_pixel(0, 0, 255, 0, 63);
    play_plan();

    set_thirds(2'd0);
    random_pixels(pixels_sent + PHASE_PIXELS);
    in_gap_pct    = 0;
    out_stall_pct = 0;
    set_thirds(2'd1);
    random_pixels(pixels_sent + PHASE_PIXELS);
    in_gap_pct    = 6;
    out_stall_pct = 6;
    set_thirds(2'd2);
    random_pixels(pixels_sent + PHASE_PIXELS);
    set_thirds(2'd3);
    random_pixels(pixels_sent + PHASE_PIXELS);

    // an error halts the block for good, so only one fault per run
    fault_pick = $urandom_range(2);
    if (fault_pick == 0) begin
      add_known(128, 0, 0, 0, 9, KIND_BAD, '0, '0, '0, '0, 8'd1, 8'd1);
    end else if (fault_pick == 1) begin
      add_known(192, 255, 0, 1023, 63, KIND_BAD, '0, '0, '0, '0, 8'd255, 8'd255);
    end else begin
      add_pixel(0, 0, 0, 33, 0);
      add_pixel(0, 0, 192, 33, 1);
      add_known(192, 0, 0, 33, 2, KIND_THIRD, '0, '0, '0, '0, 8'd10, 8'd8);
    end
    add_pixel(0, 0, 0, 1, 0);
    add_pixel(255, 255, 255, 1, 63);
    add_pixel(0, 0, 192, 2, 63);
    play_plan();

    @(negedge clk);
    in_push = 1'b0;
    while (screen_bytes_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("spectrum_cell_attribute_encoder_top regression: pass");
    end else begin
      $display("spectrum_cell_attribute_encoder_top regression: fail");
    end
    $finish;
  end

endmodule

FILE: spectrum_cell_attribute_encoder_top.f
rtl/core/scae_pkg.sv
rtl/core/scae_front.sv
rtl/core/scae_queue.sv
rtl/core/scae_back.sv
rtl/core/spectrum_cell_attribute_encoder_top.sv
tb/sv/spectrum_cell_attribute_encoder_top_test.sv
